// ===== src/spfr_pkg.sv =====
// Shared constants and types for the serial port FIFO register block.
package spfr_pkg;

  // Entries in each character FIFO.
  localparam int unsigned FifoDepth = 128;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  // The fill count never exceeds FifoDepth-1, so it fits in the pointer width.
  localparam int unsigned CntW      = PtrW;
  localparam int unsigned CharW     = 7;
  localparam int unsigned LimitW    = 7;

  localparam logic [PtrW-1:0] PtrLast  = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(FifoDepth - 1);
  localparam logic [LimitW-1:0] LimitReset = 7'd35;

  // Request kinds.
  localparam logic [1:0] CMD_BUS_READ  = 2'd0;
  localparam logic [1:0] CMD_BUS_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINE_RX   = 2'd2;
  localparam logic [1:0] CMD_TX_TICK   = 2'd3;

  // Bus register selection.
  localparam logic SEL_STATUS = 1'b0;
  localparam logic SEL_DATA   = 1'b1;

  localparam logic [7:0] READ_EMPTY = 8'hFF;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic commit;   // apply the request and load the result register
  } spfr_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } spfr_stat_t;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrLast) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

endpackage

// ===== src/spfr_ctrl.sv =====
// Controller state machine for the serial port FIFO register block.
module spfr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  spfr_pkg::spfr_stat_t stat_i,
  output spfr_pkg::spfr_ctl_t  ctl_o
);
  import spfr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    ctl_o.capture = 1'b0;
    ctl_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The FIFO read data is ready now; finish once the result slot is free.
        if (stat_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/spfr_datapath.sv =====
// FIFO storage, pointers, counts, limit register and result register.
module spfr_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spfr_pkg::spfr_ctl_t       ctl_i,
  output spfr_pkg::spfr_stat_t      stat_o,
  input  logic [1:0]                cmd_i,
  input  logic                      sel_i,
  input  logic [7:0]                data_i,
  input  logic                      cfg_we_i,
  input  logic [spfr_pkg::LimitW-1:0] cfg_wdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_read_data_o,
  output logic                      out_accepted_o,
  output logic                      out_tx_valid_o,
  output logic [spfr_pkg::CharW-1:0] out_tx_char_o
);
  import spfr_pkg::*;

  // Captured request.
  logic [1:0]       cmd_q;
  logic             sel_q;
  logic [CharW-1:0] char_q;

  logic [LimitW-1:0] limit_q;

  logic [CharW-1:0] rx_mem [FifoDepth];
  logic [CharW-1:0] tx_mem [FifoDepth];
  logic [CharW-1:0] rx_rd_q, tx_rd_q;

  logic [PtrW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PtrW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [CntW-1:0] rx_cnt_q, rx_cnt_d, tx_cnt_q, tx_cnt_d;

  logic rx_push, rx_pop, tx_push, tx_pop;

  logic             out_valid_q;
  logic [7:0]       rd_q, rd_d;
  logic             acc_q, acc_d;
  logic             tv_q, tv_d;
  logic [CharW-1:0] tc_q, tc_d;

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= cmd_i;
      sel_q  <= sel_i;
      char_q <= data_i[CharW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Head entries are read every cycle; the head does not move between capture
  // and commit, so the registered word is the one a pop needs.
  always_ff @(posedge clk_i) begin
    rx_rd_q <= rx_mem[rx_head_q];
    if (rx_push) begin
      rx_mem[rx_tail_q] <= char_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_rd_q <= tx_mem[tx_head_q];
    if (tx_push) begin
      tx_mem[tx_tail_q] <= char_q;
    end
  end

  always_comb begin
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    tx_push = 1'b0;
    tx_pop  = 1'b0;
    rd_d    = '0;
    acc_d   = 1'b0;
    tv_d    = 1'b0;
    tc_d    = '0;
    unique case (cmd_q)
      CMD_BUS_READ: begin
        if (sel_q == SEL_STATUS) begin
          rd_d = {6'b0, rx_cnt_q != '0, tx_cnt_q < CntFull};
        end else if (rx_cnt_q != '0) begin
          rd_d   = {1'b0, rx_rd_q};
          rx_pop = ctl_i.commit;
        end else begin
          rd_d = READ_EMPTY;
        end
      end
      CMD_BUS_WRITE: begin
        if (sel_q == SEL_DATA && tx_cnt_q < CntFull) begin
          acc_d   = 1'b1;
          tx_push = ctl_i.commit;
        end
      end
      CMD_LINE_RX: begin
        if (32'(rx_cnt_q) < 32'(limit_q) && rx_cnt_q < CntFull) begin
          acc_d   = 1'b1;
          rx_push = ctl_i.commit;
        end
      end
      CMD_TX_TICK: begin
        if (tx_cnt_q != '0) begin
          tv_d   = 1'b1;
          tc_d   = tx_rd_q;
          tx_pop = ctl_i.commit;
        end
      end
      default: ;
    endcase
  end

  // Pointer and count updates; both pointers return to zero when a pop empties.
  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    tx_cnt_d  = tx_cnt_q;
    if (rx_push) begin
      rx_tail_d = next_ptr(rx_tail_q);
      rx_cnt_d  = rx_cnt_q + CntW'(1);
    end
    if (rx_pop) begin
      rx_cnt_d = rx_cnt_q - CntW'(1);
      if (rx_cnt_q == CntW'(1)) begin
        rx_head_d = '0;
        rx_tail_d = '0;
      end else begin
        rx_head_d = next_ptr(rx_head_q);
      end
    end
    if (tx_push) begin
      tx_tail_d = next_ptr(tx_tail_q);
      tx_cnt_d  = tx_cnt_q + CntW'(1);
    end
    if (tx_pop) begin
      tx_cnt_d = tx_cnt_q - CntW'(1);
      if (tx_cnt_q == CntW'(1)) begin
        tx_head_d = '0;
        tx_tail_d = '0;
      end else begin
        tx_head_d = next_ptr(tx_head_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      rx_cnt_q  <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      tx_cnt_q  <= '0;
    end else begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      tx_cnt_q  <= tx_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      rd_q  <= rd_d;
      acc_q <= acc_d;
      tv_q  <= tv_d;
      tc_q  <= tc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_read_data_o = rd_q;
  assign out_accepted_o  = acc_q;
  assign out_tx_valid_o  = tv_q;
  assign out_tx_char_o   = tc_q;

endmodule

// ===== src/serial_port_fifo_registers.sv =====
// Top level of the serial port with receive and transmit character FIFOs.
//
// Every request on the slave stream is one event: a bus read or write of the
// status or data register, a character arriving from the line, or a tick from
// the transmitter asking for the next character. Each request yields exactly
// one result on the master stream carrying the read byte, whether a character
// was stored, and the character handed to the transmitter, if any.
//
// A request is captured in the idle state, while the head entries of both
// FIFO memories are read into registers, and is applied in the execute
// state once the result register is free, when that register is loaded.
// The registered read port of the FIFO memories is why a request needs
// both states; one request is in flight at a time, so a new request is not
// taken before the last one is applied, and the result is offered on the
// master side from the edge at which the request is applied.
//
// When the receiver stalls, the result stays in the output register and the
// block accepts one more request, holding it until the output register frees.
// Reset empties both FIFOs, clears their pointers and sets the receive limit
// to 35; memory contents are not cleared since unwritten entries are never read.
module serial_port_fifo_registers (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_in
  input  logic [2:0]  s_axis_tuser_i,   // [1:0] cmd, [2] port_select
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data, [8] accepted, [9] tx_valid, [16:10] tx_char, [23:17] zero
  output logic [23:0] m_axis_tdata_o,
  // Receive limit register.
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);
  import spfr_pkg::*;

  spfr_ctl_t  ctl;
  spfr_stat_t stat;

  logic [7:0]       read_data;
  logic             accepted;
  logic             tx_valid;
  logic [CharW-1:0] tx_char;

  spfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  spfr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .cmd_i           (s_axis_tuser_i[1:0]),
    .sel_i           (s_axis_tuser_i[2]),
    .data_i          (s_axis_tdata_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_read_data_o (read_data),
    .out_accepted_o  (accepted),
    .out_tx_valid_o  (tx_valid),
    .out_tx_char_o   (tx_char)
  );

  assign m_axis_tdata_o = {7'b0, tx_char, tx_valid, accepted, read_data};

endmodule
